@@ hw/rtl/pbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbp_pkg
// Shared types, widths and the multiply step table of the polygon
// bounding box and plane unit.
// ----------------------------------------------------------------------------
package pbp_pkg;

	localparam int COORD_W = 32;
	localparam int EPS_W   = 31;
	localparam int TYPE_W  = 4;
	localparam int DL_W    = 34;
	localparam int C_W     = 66;
	localparam int NORM_W  = 67;
	localparam int ACC_W   = 100;
	localparam int DIV_W   = 68;
	localparam int STEP_W  = 5;
	localparam int STEPS_A = 14;
	localparam int STEPS   = 23;
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = 1;

	typedef logic signed [COORD_W-1:0] coord_t;

	// box order: x max, x min, y max, y min, z max, z min
	typedef struct packed {
		coord_t [5:0]      box;
		coord_t [8:0]      corner;
		logic              three;
		logic [TYPE_W-1:0] etype;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef enum logic [3:0] {
		SRC_E1X, SRC_E1Y, SRC_E1Z, SRC_E2X, SRC_E2Y, SRC_E2Z,
		SRC_DL1, SRC_DL2, SRC_EPS, SRC_T,
		SRC_CA, SRC_CB, SRC_CC, SRC_X1, SRC_Y1, SRC_Z1
	} src_t;

	typedef enum logic [2:0] {
		DST_NONE, DST_T, DST_CA, DST_CB, DST_CC, DST_RHS, DST_DD
	} dst_t;

	typedef struct packed {
		src_t       a_src;
		logic [1:0] a_chunk;
		src_t       b_src;
		logic       b_chunk;
		logic       neg;
		logic       first;
		dst_t       dst;
	} step_t;

	function automatic step_t mk_step(input src_t a, input logic [1:0] ac, input src_t b,
		input logic bc, input logic ng, input logic fs, input dst_t d);
		step_t s;
		s.a_src   = a;
		s.a_chunk = ac;
		s.b_src   = b;
		s.b_chunk = bc;
		s.neg     = ng;
		s.first   = fs;
		s.dst     = d;
		return s;
	endfunction

	// one 32x32 partial product per step, summed into the accumulator
	function automatic step_t step_ctrl(input logic [STEP_W-1:0] idx);
		step_t s;
		unique case (idx)
			5'd0: s = mk_step(SRC_DL1, 2'd0, SRC_EPS, 1'b0, 1'b0, 1'b1, DST_NONE);
			5'd1: s = mk_step(SRC_DL1, 2'd1, SRC_EPS, 1'b0, 1'b0, 1'b0, DST_T);
			5'd2: s = mk_step(SRC_E1Y, 2'd0, SRC_E2Z, 1'b0, 1'b0, 1'b1, DST_NONE);
			5'd3: s = mk_step(SRC_E1Z, 2'd0, SRC_E2Y, 1'b0, 1'b1, 1'b0, DST_CA);
			5'd4: s = mk_step(SRC_E1Z, 2'd0, SRC_E2X, 1'b0, 1'b0, 1'b1, DST_NONE);
			5'd5: s = mk_step(SRC_E1X, 2'd0, SRC_E2Z, 1'b0, 1'b1, 1'b0, DST_CB);
			5'd6: s = mk_step(SRC_E1X, 2'd0, SRC_E2Y, 1'b0, 1'b0, 1'b1, DST_NONE);
			5'd7: s = mk_step(SRC_E1Y, 2'd0, SRC_E2X, 1'b0, 1'b1, 1'b0, DST_CC);
			5'd8: s = mk_step(SRC_T, 2'd0, SRC_DL2, 1'b0, 1'b0, 1'b1, DST_NONE);
			5'd9: s = mk_step(SRC_T, 2'd1, SRC_DL2, 1'b0, 1'b0, 1'b0, DST_NONE);
			5'd10: s = mk_step(SRC_T, 2'd2, SRC_DL2, 1'b0, 1'b0, 1'b0, DST_NONE);
			5'd11: s = mk_step(SRC_T, 2'd0, SRC_DL2, 1'b1, 1'b0, 1'b0, DST_NONE);
			5'd12: s = mk_step(SRC_T, 2'd1, SRC_DL2, 1'b1, 1'b0, 1'b0, DST_NONE);
			5'd13: s = mk_step(SRC_T, 2'd2, SRC_DL2, 1'b1, 1'b0, 1'b0, DST_RHS);
			5'd14: s = mk_step(SRC_CA, 2'd0, SRC_X1, 1'b0, 1'b1, 1'b1, DST_NONE);
			5'd15: s = mk_step(SRC_CA, 2'd1, SRC_X1, 1'b0, 1'b1, 1'b0, DST_NONE);
			5'd16: s = mk_step(SRC_CA, 2'd2, SRC_X1, 1'b0, 1'b1, 1'b0, DST_NONE);
			5'd17: s = mk_step(SRC_CB, 2'd0, SRC_Y1, 1'b0, 1'b1, 1'b0, DST_NONE);
			5'd18: s = mk_step(SRC_CB, 2'd1, SRC_Y1, 1'b0, 1'b1, 1'b0, DST_NONE);
			5'd19: s = mk_step(SRC_CB, 2'd2, SRC_Y1, 1'b0, 1'b1, 1'b0, DST_NONE);
			5'd20: s = mk_step(SRC_CC, 2'd0, SRC_Z1, 1'b0, 1'b1, 1'b0, DST_NONE);
			5'd21: s = mk_step(SRC_CC, 2'd1, SRC_Z1, 1'b0, 1'b1, 1'b0, DST_NONE);
			5'd22: s = mk_step(SRC_CC, 2'd2, SRC_Z1, 1'b0, 1'b1, 1'b0, DST_DD);
			default: s = mk_step(SRC_EPS, 2'd0, SRC_EPS, 1'b0, 1'b0, 1'b1, DST_NONE);
		endcase
		return s;
	endfunction

endpackage

@@ hw/rtl/pbp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbp_front
// Node intake: running bounding box, first three corners and node count.
// The last node of an element pushes one job into the queue.
// ----------------------------------------------------------------------------
module pbp_front #(
	parameter int MAX_NODES = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic signed [pbp_pkg::COORD_W-1:0] px,
	input  logic signed [pbp_pkg::COORD_W-1:0] py,
	input  logic signed [pbp_pkg::COORD_W-1:0] pz,
	input  logic                            last_node,
	input  logic [pbp_pkg::TYPE_W-1:0]      elem_type,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  pbp_pkg::qstat_t                 qstat,
	output logic                            push,
	output pbp_pkg::job_t                   push_job
);

	localparam int CNT_W = $clog2(MAX_NODES + 1);

	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         cnt_d;
	pbp_pkg::coord_t [5:0]    box_q;
	pbp_pkg::coord_t [8:0]    corner_q;
	pbp_pkg::coord_t [5:0]    box_d;
	pbp_pkg::coord_t [8:0]    corner_d;
	pbp_pkg::coord_t [2:0]    p;
	logic                     keep;
	logic                     take;

	assign p        = {pz, py, px};
	assign in_stall = qstat.full;
	assign take     = in_valid && !in_stall;
	assign keep     = cnt_q < CNT_W'(MAX_NODES);

	always_comb begin
		box_d    = box_q;
		corner_d = corner_q;
		cnt_d    = cnt_q;
		if (keep) begin
			cnt_d = cnt_q + CNT_W'(1);
			for (int k = 0; k < 3; k++) begin
				if (cnt_q == '0 || $signed(p[k]) > $signed(box_q[2*k]))
					box_d[2*k] = p[k];
				if (cnt_q == '0 || $signed(p[k]) < $signed(box_q[2*k+1]))
					box_d[2*k+1] = p[k];
				for (int n = 0; n < 3; n++) begin
					if (cnt_q == CNT_W'(n))
						corner_d[3*n+k] = p[k];
				end
			end
		end
	end

	assign push           = take && last_node;
	assign push_job.box   = box_d;
	assign push_job.corner = corner_d;
	assign push_job.three = cnt_d >= CNT_W'(3);
	assign push_job.etype = elem_type;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (take) begin
			cnt_q <= last_node ? '0 : cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			box_q    <= box_d;
			corner_q <= corner_d;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_NODES))
		else $error("node count beyond limit");

endmodule

@@ hw/rtl/pbp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbp_queue
// Two-entry job queue between node intake and the plane engine.
// ----------------------------------------------------------------------------
module pbp_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pbp_pkg::job_t   push_job,
	input  logic            pop,
	output pbp_pkg::job_t   head,
	output pbp_pkg::qstat_t qstat
);

	pbp_pkg::job_t              mem_q [pbp_pkg::Q_DEPTH];
	logic [pbp_pkg::Q_AW-1:0]   wr_q;
	logic [pbp_pkg::Q_AW-1:0]   rd_q;
	logic [pbp_pkg::Q_AW:0]     cnt_q;

	assign head        = mem_q[rd_q];
	assign qstat.full  = cnt_q == (pbp_pkg::Q_AW+1)'(pbp_pkg::Q_DEPTH);
	assign qstat.empty = cnt_q == '0;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + pbp_pkg::Q_AW'(1);
			if (pop)
				rd_q <= rd_q + pbp_pkg::Q_AW'(1);
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + (pbp_pkg::Q_AW+1)'(1);
				2'b01: cnt_q <= cnt_q - (pbp_pkg::Q_AW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("job pushed into full queue");

endmodule

@@ hw/rtl/pbp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbp_back
// Plane engine: edge vectors, cross product, offset and degeneracy bound on
// one shared 32x32 multiplier, then four serial divisions by the L1 norm
// unless the plane is degenerate. Holds the result in an output register.
// ----------------------------------------------------------------------------
module pbp_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [pbp_pkg::EPS_W-1:0]           eps,
	input  pbp_pkg::qstat_t                     qstat,
	input  pbp_pkg::job_t                       head,
	output logic                                pop,
	output logic signed [pbp_pkg::COORD_W-1:0]  x_max,
	output logic signed [pbp_pkg::COORD_W-1:0]  x_min,
	output logic signed [pbp_pkg::COORD_W-1:0]  y_max,
	output logic signed [pbp_pkg::COORD_W-1:0]  y_min,
	output logic signed [pbp_pkg::COORD_W-1:0]  z_max,
	output logic signed [pbp_pkg::COORD_W-1:0]  z_min,
	output logic signed [pbp_pkg::COORD_W-1:0]  plane_a,
	output logic signed [pbp_pkg::COORD_W-1:0]  plane_b,
	output logic signed [pbp_pkg::COORD_W-1:0]  plane_c,
	output logic signed [pbp_pkg::COORD_W-1:0]  plane_d,
	output logic                                plane_made,
	output logic [pbp_pkg::TYPE_W-1:0]          new_type,
	output logic                                out_valid,
	input  logic                                out_stall
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_SETUP  = 11'b00000000010,
		S_MULA   = 11'b00000000100,
		S_DRAINA = 11'b00000001000,
		S_MAG    = 11'b00000010000,
		S_MULB   = 11'b00000100000,
		S_DRAINB = 11'b00001000000,
		S_DMAG   = 11'b00010000000,
		S_CMP    = 11'b00100000000,
		S_DIV    = 11'b01000000000,
		S_DONE   = 11'b10000000000
	} state_t;

	state_t                          state_q;
	pbp_pkg::job_t                   job_q;

	// setup results
	logic [31:0]                     e1m_q [3];
	logic [31:0]                     e2m_q [3];
	logic                            e1s_q [3];
	logic                            e2s_q [3];
	logic [31:0]                     p1m_q [3];
	logic                            p1s_q [3];
	logic [pbp_pkg::DL_W-1:0]        dl1_q;
	logic [pbp_pkg::DL_W-1:0]        dl2_q;
	logic signed [32:0]              d1_w [3];
	logic signed [32:0]              d2_w [3];
	logic [31:0]                     e1m_d [3];
	logic [31:0]                     e2m_d [3];
	logic [31:0]                     p1m_d [3];
	logic [pbp_pkg::DL_W-1:0]        dl1_d;
	logic [pbp_pkg::DL_W-1:0]        dl2_d;

	// multiply pipeline
	logic [pbp_pkg::STEP_W-1:0]      step_q;
	pbp_pkg::step_t                  ctrl;
	logic [127:0]                    op_mag [16];
	logic                            op_sgn [16];
	logic [31:0]                     a_word;
	logic [31:0]                     b_word;
	logic [63:0]                     prod_w;
	logic                            issue;
	logic                            vld_s1;
	logic [63:0]                     prod_s1;
	logic                            neg_s1;
	logic [1:0]                      sh_s1;
	logic                            first_s1;
	pbp_pkg::dst_t                   dst_s1;
	logic [pbp_pkg::ACC_W-1:0]       ext;
	logic [pbp_pkg::ACC_W-1:0]       addend;
	logic [pbp_pkg::ACC_W-1:0]       sum;
	logic [pbp_pkg::ACC_W-1:0]       acc_q;

	// products and magnitudes
	logic [pbp_pkg::C_W-1:0]         t_q;
	logic [pbp_pkg::C_W-1:0]         ca_q;
	logic [pbp_pkg::C_W-1:0]         cb_q;
	logic [pbp_pkg::C_W-1:0]         cc_q;
	logic [pbp_pkg::C_W-1:0]         cam_q;
	logic [pbp_pkg::C_W-1:0]         cbm_q;
	logic [pbp_pkg::C_W-1:0]         ccm_q;
	logic [pbp_pkg::ACC_W-1:0]       rhs_q;
	logic [pbp_pkg::ACC_W-1:0]       dd_q;
	logic [pbp_pkg::ACC_W-1:0]       ddm_q;
	logic [pbp_pkg::NORM_W-1:0]      norm_q;
	logic                            pass_q;
	logic                            ovf_q;

	// divider
	logic [1:0]                      div_idx_q;
	logic [4:0]                      cnt_q;
	logic [pbp_pkg::DIV_W-1:0]       r_q;
	logic [31:0]                     l_q;
	logic [31:0]                     q_q;
	logic [31:0]                     qres_q [4];
	logic [1:0]                      ld_idx;
	logic [pbp_pkg::DIV_W-1:0]       ld_r;
	logic [31:0]                     ld_l;
	logic [pbp_pkg::DIV_W-1:0]       tdiv;
	logic                            ge;
	logic [pbp_pkg::DIV_W-1:0]       rnext;

	// result
	logic                            flip;
	logic [31:0]                     res_a;
	logic [31:0]                     res_b;
	logic [31:0]                     res_c;
	logic [31:0]                     res_d;
	logic [pbp_pkg::TYPE_W-1:0]      res_type;
	logic                            load_out;

	assign pop      = (state_q == S_IDLE) && !qstat.empty;
	assign load_out = (state_q == S_DONE) && (!out_valid || !out_stall);
	assign issue    = (state_q == S_MULA) || (state_q == S_MULB);

	// edge vectors from the first corner
	always_comb begin
		dl1_d = '0;
		dl2_d = '0;
		for (int k = 0; k < 3; k++) begin
			d1_w[k] = {job_q.corner[3+k][31], job_q.corner[3+k]}
				- {job_q.corner[k][31], job_q.corner[k]};
			d2_w[k] = {job_q.corner[6+k][31], job_q.corner[6+k]}
				- {job_q.corner[k][31], job_q.corner[k]};
			e1m_d[k] = d1_w[k][32] ? 32'(-d1_w[k]) : d1_w[k][31:0];
			e2m_d[k] = d2_w[k][32] ? 32'(-d2_w[k]) : d2_w[k][31:0];
			p1m_d[k] = job_q.corner[k][31] ? 32'(-job_q.corner[k]) : job_q.corner[k];
			dl1_d = dl1_d + pbp_pkg::DL_W'(e1m_d[k]);
			dl2_d = dl2_d + pbp_pkg::DL_W'(e2m_d[k]);
		end
	end

	// operand magnitudes and signs for the shared multiplier
	always_comb begin
		op_mag[pbp_pkg::SRC_E1X] = 128'(e1m_q[0]);
		op_mag[pbp_pkg::SRC_E1Y] = 128'(e1m_q[1]);
		op_mag[pbp_pkg::SRC_E1Z] = 128'(e1m_q[2]);
		op_mag[pbp_pkg::SRC_E2X] = 128'(e2m_q[0]);
		op_mag[pbp_pkg::SRC_E2Y] = 128'(e2m_q[1]);
		op_mag[pbp_pkg::SRC_E2Z] = 128'(e2m_q[2]);
		op_mag[pbp_pkg::SRC_DL1] = 128'(dl1_q);
		op_mag[pbp_pkg::SRC_DL2] = 128'(dl2_q);
		op_mag[pbp_pkg::SRC_EPS] = 128'(eps);
		op_mag[pbp_pkg::SRC_T]   = 128'(t_q);
		op_mag[pbp_pkg::SRC_CA]  = 128'(cam_q);
		op_mag[pbp_pkg::SRC_CB]  = 128'(cbm_q);
		op_mag[pbp_pkg::SRC_CC]  = 128'(ccm_q);
		op_mag[pbp_pkg::SRC_X1]  = 128'(p1m_q[0]);
		op_mag[pbp_pkg::SRC_Y1]  = 128'(p1m_q[1]);
		op_mag[pbp_pkg::SRC_Z1]  = 128'(p1m_q[2]);
		op_sgn[pbp_pkg::SRC_E1X] = e1s_q[0];
		op_sgn[pbp_pkg::SRC_E1Y] = e1s_q[1];
		op_sgn[pbp_pkg::SRC_E1Z] = e1s_q[2];
		op_sgn[pbp_pkg::SRC_E2X] = e2s_q[0];
		op_sgn[pbp_pkg::SRC_E2Y] = e2s_q[1];
		op_sgn[pbp_pkg::SRC_E2Z] = e2s_q[2];
		op_sgn[pbp_pkg::SRC_DL1] = 1'b0;
		op_sgn[pbp_pkg::SRC_DL2] = 1'b0;
		op_sgn[pbp_pkg::SRC_EPS] = 1'b0;
		op_sgn[pbp_pkg::SRC_T]   = 1'b0;
		op_sgn[pbp_pkg::SRC_CA]  = ca_q[pbp_pkg::C_W-1];
		op_sgn[pbp_pkg::SRC_CB]  = cb_q[pbp_pkg::C_W-1];
		op_sgn[pbp_pkg::SRC_CC]  = cc_q[pbp_pkg::C_W-1];
		op_sgn[pbp_pkg::SRC_X1]  = p1s_q[0];
		op_sgn[pbp_pkg::SRC_Y1]  = p1s_q[1];
		op_sgn[pbp_pkg::SRC_Z1]  = p1s_q[2];
	end

	assign ctrl   = pbp_pkg::step_ctrl(step_q);
	assign a_word = op_mag[ctrl.a_src][{ctrl.a_chunk, 5'd0} +: 32];
	assign b_word = op_mag[ctrl.b_src][{ctrl.b_chunk, 5'd0} +: 32];
	assign prod_w = a_word * b_word;

	// accumulate stage
	assign ext    = pbp_pkg::ACC_W'(prod_s1) << {sh_s1, 5'd0};
	assign addend = neg_s1 ? -ext : ext;
	assign sum    = (first_s1 ? '0 : acc_q) + addend;

	// divider: one quotient bit per cycle
	always_comb begin
		ld_idx = (state_q == S_CMP) ? 2'd0 : div_idx_q + 2'd1;
		unique case (ld_idx)
			2'd0: begin
				ld_r = pbp_pkg::DIV_W'(cam_q >> 2);
				ld_l = {cam_q[1:0], 30'd0};
			end
			2'd1: begin
				ld_r = pbp_pkg::DIV_W'(cbm_q >> 2);
				ld_l = {cbm_q[1:0], 30'd0};
			end
			2'd2: begin
				ld_r = pbp_pkg::DIV_W'(ccm_q >> 2);
				ld_l = {ccm_q[1:0], 30'd0};
			end
			default: begin
				ld_r = ddm_q[pbp_pkg::ACC_W-1:32];
				ld_l = ddm_q[31:0];
			end
		endcase
	end

	assign tdiv  = {r_q[pbp_pkg::DIV_W-2:0], l_q[31]};
	assign ge    = tdiv >= pbp_pkg::DIV_W'(norm_q);
	assign rnext = ge ? tdiv - pbp_pkg::DIV_W'(norm_q) : tdiv;

	// sign fix so that b is never negative, offset saturated
	always_comb begin
		flip  = cb_q[pbp_pkg::C_W-1];
		res_a = '0;
		res_b = '0;
		res_c = '0;
		res_d = '0;
		if (pass_q) begin
			res_a = (ca_q[pbp_pkg::C_W-1] != flip) ? -qres_q[0] : qres_q[0];
			res_b = qres_q[1];
			res_c = (cc_q[pbp_pkg::C_W-1] != flip) ? -qres_q[2] : qres_q[2];
			if (dd_q[pbp_pkg::ACC_W-1] != flip) begin
				if (ovf_q || qres_q[3] > 32'h8000_0000)
					res_d = 32'h8000_0000;
				else
					res_d = -qres_q[3];
			end else begin
				if (ovf_q || qres_q[3][31])
					res_d = 32'h7fff_ffff;
				else
					res_d = qres_q[3];
			end
		end
		res_type = job_q.etype;
		if (job_q.three && res_b < 32'(eps))
			res_type = job_q.etype + pbp_pkg::TYPE_W'(2);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= '0;
			vld_s1    <= 1'b0;
			out_valid <= 1'b0;
			div_idx_q <= '0;
			cnt_q     <= '0;
		end else begin
			vld_s1 <= issue;
			if (load_out)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop)
						state_q <= head.three ? S_SETUP : S_DONE;
				end
				S_SETUP: begin
					step_q  <= '0;
					state_q <= S_MULA;
				end
				S_MULA: begin
					step_q <= step_q + pbp_pkg::STEP_W'(1);
					if (step_q == pbp_pkg::STEP_W'(pbp_pkg::STEPS_A - 1))
						state_q <= S_DRAINA;
				end
				S_DRAINA: state_q <= S_MAG;
				S_MAG:    state_q <= S_MULB;
				S_MULB: begin
					step_q <= step_q + pbp_pkg::STEP_W'(1);
					if (step_q == pbp_pkg::STEP_W'(pbp_pkg::STEPS - 1))
						state_q <= S_DRAINB;
				end
				S_DRAINB: state_q <= S_DMAG;
				S_DMAG:   state_q <= S_CMP;
				S_CMP: begin
					div_idx_q <= '0;
					cnt_q     <= '0;
					state_q   <= ({norm_q, 30'd0} > rhs_q) ? S_DIV : S_DONE;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						div_idx_q <= div_idx_q + 2'd1;
						if (div_idx_q == 2'd3)
							state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q  <= head;
			pass_q <= 1'b0;
		end
		if (state_q == S_SETUP) begin
			for (int k = 0; k < 3; k++) begin
				e1m_q[k] <= e1m_d[k];
				e2m_q[k] <= e2m_d[k];
				e1s_q[k] <= d1_w[k][32];
				e2s_q[k] <= d2_w[k][32];
				p1m_q[k] <= p1m_d[k];
				p1s_q[k] <= job_q.corner[k][31];
			end
			dl1_q <= dl1_d;
			dl2_q <= dl2_d;
		end
		prod_s1  <= prod_w;
		neg_s1   <= op_sgn[ctrl.a_src] ^ op_sgn[ctrl.b_src] ^ ctrl.neg;
		sh_s1    <= ctrl.a_chunk + 2'(ctrl.b_chunk);
		first_s1 <= ctrl.first;
		dst_s1   <= ctrl.dst;
		if (vld_s1) begin
			unique case (dst_s1)
				pbp_pkg::DST_NONE: acc_q <= sum;
				pbp_pkg::DST_T:    t_q   <= sum[pbp_pkg::C_W-1:0];
				pbp_pkg::DST_CA:   ca_q  <= sum[pbp_pkg::C_W-1:0];
				pbp_pkg::DST_CB:   cb_q  <= sum[pbp_pkg::C_W-1:0];
				pbp_pkg::DST_CC:   cc_q  <= sum[pbp_pkg::C_W-1:0];
				pbp_pkg::DST_RHS:  rhs_q <= sum;
				pbp_pkg::DST_DD:   dd_q  <= sum;
				default:           acc_q <= sum;
			endcase
		end
		if (state_q == S_MAG) begin
			cam_q <= ca_q[pbp_pkg::C_W-1] ? -ca_q : ca_q;
			cbm_q <= cb_q[pbp_pkg::C_W-1] ? -cb_q : cb_q;
			ccm_q <= cc_q[pbp_pkg::C_W-1] ? -cc_q : cc_q;
		end
		if (state_q == S_DMAG) begin
			ddm_q  <= dd_q[pbp_pkg::ACC_W-1] ? -dd_q : dd_q;
			norm_q <= pbp_pkg::NORM_W'(cam_q) + pbp_pkg::NORM_W'(cbm_q)
				+ pbp_pkg::NORM_W'(ccm_q);
		end
		if (state_q == S_CMP) begin
			pass_q <= {norm_q, 30'd0} > rhs_q;
			ovf_q  <= ddm_q >= pbp_pkg::ACC_W'({norm_q, 32'd0});
		end
		if (state_q == S_CMP || (state_q == S_DIV && cnt_q == 5'd31)) begin
			r_q <= ld_r;
			l_q <= ld_l;
			q_q <= '0;
		end else if (state_q == S_DIV) begin
			r_q <= rnext;
			l_q <= {l_q[30:0], 1'b0};
			q_q <= {q_q[30:0], ge};
		end
		if (state_q == S_DIV && cnt_q == 5'd31)
			qres_q[div_idx_q] <= {q_q[30:0], ge};
		if (load_out) begin
			x_max      <= job_q.box[0];
			x_min      <= job_q.box[1];
			y_max      <= job_q.box[2];
			y_min      <= job_q.box[3];
			z_max      <= job_q.box[4];
			z_min      <= job_q.box[5];
			plane_a    <= res_a;
			plane_b    <= res_b;
			plane_c    <= res_c;
			plane_d    <= res_d;
			plane_made <= job_q.three;
			new_type   <= res_type;
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (norm_q != '0))
		else $error("division started with zero norm");

	a_b_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !plane_b[31])
		else $error("plane b negative");

	a_no_plane: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !plane_made) |->
			(plane_a == '0 && plane_b == '0 && plane_c == '0 && plane_d == '0))
		else $error("plane without three nodes");

endmodule

@@ hw/rtl/polygon_bbox_and_plane_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_bbox_and_plane_unit
// Bounding box and normalized plane equation of elements of up to MAX_NODES
// nodes, one node per input transfer, one result per element.
// ----------------------------------------------------------------------------
// Each node transfer is taken unless input stalls; the last node of an element
// places a job in a two-entry queue and input stalls only while that queue
// is full. The plane engine handles one element at a time: for three or more
// nodes it runs 23 steps of one shared 32x32 multiplier, setup and compare
// states, and four divisions by the L1 norm on a one bit per cycle divider;
// the divisions are skipped when the plane is degenerate, and an element
// with fewer nodes goes straight to the result. The result sits in an
// output register while the engine works on the next job.
module polygon_bbox_and_plane_unit #(
	parameter int MAX_NODES = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                eps_we,
	input  logic [pbp_pkg::EPS_W-1:0]           eps_wdata,
	input  logic signed [pbp_pkg::COORD_W-1:0]  px,
	input  logic signed [pbp_pkg::COORD_W-1:0]  py,
	input  logic signed [pbp_pkg::COORD_W-1:0]  pz,
	input  logic                                last_node,
	input  logic [pbp_pkg::TYPE_W-1:0]          elem_type,
	input  logic                                in_valid,
	output logic                                in_stall,
	output logic signed [pbp_pkg::COORD_W-1:0]  x_max,
	output logic signed [pbp_pkg::COORD_W-1:0]  x_min,
	output logic signed [pbp_pkg::COORD_W-1:0]  y_max,
	output logic signed [pbp_pkg::COORD_W-1:0]  y_min,
	output logic signed [pbp_pkg::COORD_W-1:0]  z_max,
	output logic signed [pbp_pkg::COORD_W-1:0]  z_min,
	output logic signed [pbp_pkg::COORD_W-1:0]  plane_a,
	output logic signed [pbp_pkg::COORD_W-1:0]  plane_b,
	output logic signed [pbp_pkg::COORD_W-1:0]  plane_c,
	output logic signed [pbp_pkg::COORD_W-1:0]  plane_d,
	output logic                                plane_made,
	output logic [pbp_pkg::TYPE_W-1:0]          new_type,
	output logic                                out_valid,
	input  logic                                out_stall
);

	localparam logic [pbp_pkg::EPS_W-1:0] EPS_RESET = 31'd1074;

	logic [pbp_pkg::EPS_W-1:0] eps_q;
	pbp_pkg::qstat_t           qstat;
	pbp_pkg::job_t             push_job;
	pbp_pkg::job_t             head;
	logic                      push;
	logic                      pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (eps_we) begin
			eps_q <= eps_wdata;
		end
	end

	pbp_front #(
		.MAX_NODES (MAX_NODES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.px        (px),
		.py        (py),
		.pz        (pz),
		.last_node (last_node),
		.elem_type (elem_type),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.qstat     (qstat),
		.push      (push),
		.push_job  (push_job)
	);

	pbp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	pbp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.eps        (eps_q),
		.qstat      (qstat),
		.head       (head),
		.pop        (pop),
		.x_max      (x_max),
		.x_min      (x_min),
		.y_max      (y_max),
		.y_min      (y_min),
		.z_max      (z_max),
		.z_min      (z_min),
		.plane_a    (plane_a),
		.plane_b    (plane_b),
		.plane_c    (plane_c),
		.plane_d    (plane_d),
		.plane_made (plane_made),
		.new_type   (new_type),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

endmodule
